// ----- src/lbch_pkg.sv -----
// Package for the load-based core hotplug controller.
// Holds field widths, codes, transfer structs and the percent-scaling helper.
// No dependencies.
package lbch_pkg;

	// Field widths of the command and result transfers.
	localparam int FUNC_W    = 2;
	localparam int RATE_W    = 22;
	localparam int ACTION_W  = 2;
	localparam int CHANGED_W = 2;
	localparam int MASK_W    = 4;
	localparam int COUNT_W   = 3;

	// Configuration register widths.
	localparam int CORES_W     = 3;
	localparam int PCT_W       = 7;
	localparam int TICK_W      = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	// Number of cores that have a rate field; higher cores read rate zero.
	localparam int RATE_INPUTS = 4;

	// Divisor that turns percent times peak rate into a limit.
	localparam int PCT_SCALE = 100;

	// Percent times peak rate, and 100 times (rate + 1).
	localparam int PROD_W   = PCT_W + RATE_W;
	localparam int SCALED_W = RATE_W + 1 + PCT_W;

	// Configuration reset values.
	localparam logic               RST_ENABLED     = 1'b1;
	localparam logic [CORES_W-1:0] RST_MAX_CORES   = 3'd4;
	localparam logic [CORES_W-1:0] RST_MIN_CORES   = 3'd1;
	localparam logic [PCT_W-1:0]   RST_UP_PCT      = 7'd90;
	localparam logic [PCT_W-1:0]   RST_DOWN_PCT    = 7'd60;
	localparam logic [TICK_W-1:0]  RST_TICKS_UP    = 8'd1;
	localparam logic [TICK_W-1:0]  RST_TICKS_DOWN  = 8'd1;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ENABLED     = 3'd0,
		CFG_MAX_CORES   = 3'd1,
		CFG_MIN_CORES   = 3'd2,
		CFG_UP_PCT      = 3'd3,
		CFG_DOWN_PCT    = 3'd4,
		CFG_TICKS_UP    = 3'd5,
		CFG_TICKS_DOWN  = 3'd6
	} cfg_index_t;

	// Command codes.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK    = 2'd0,
		FUNC_SUSPEND = 2'd1,
		FUNC_RESUME  = 2'd2
	} func_t;

	// Result action codes.
	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE    = 2'd0,
		ACT_ONLINE  = 2'd1,
		ACT_OFFLINE = 2'd2,
		ACT_MASK    = 2'd3
	} action_t;

	// One command transfer.
	typedef struct packed {
		func_t             func;
		logic [RATE_W-1:0] rate_core0;
		logic [RATE_W-1:0] rate_core1;
		logic [RATE_W-1:0] rate_core2;
		logic [RATE_W-1:0] rate_core3;
		logic [RATE_W-1:0] peak_rate;
	} cmd_item_t;

	// One result transfer.
	typedef struct packed {
		action_t              action;
		logic [CHANGED_W-1:0] changed_core;
		logic [MASK_W-1:0]    online_mask;
		logic [COUNT_W-1:0]   online_count;
	} res_item_t;

	// 100 * (r + 1) by shift and add (100 = 64 + 32 + 4).
	function automatic logic [SCALED_W-1:0] scale_rate(input logic [RATE_W-1:0] r);
		logic [SCALED_W-1:0] v;
		v = SCALED_W'(r) + SCALED_W'(1);
		return (v << 6) + (v << 5) + (v << 2);
	endfunction

endpackage

// ----- src/load_based_core_hotplug.sv -----
// Top level of the load-based core hotplug controller.
// Depends on lbch_pkg for types, codes and the percent-scaling helper.
// Takes one command per cycle while the result register is free or being emptied; a
// command is captured in the input register and its result in the result register; the
// sustained rate is one item per clock while res_ready stays high. The rate is set by
// the update of the online mask and tick counter, which every command reads and writes.
// The percent-times-peak products are formed as a command is
// captured, so the limits are compared without any division: rate > floor(p*peak/100)
// holds exactly when p*peak < 100*rate, and rate < floor(p*peak/100) holds exactly when
// 100*(rate+1) <= p*peak. Configuration writes take effect at once and are meant to
// be made while no command is in flight.
module load_based_core_hotplug
	import lbch_pkg::*;
#(
	parameter int NUM_CORES = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  cmd_item_t              cmd,
	output logic                   res_valid,
	input  logic                   res_ready,
	output res_item_t              res,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_W    = $clog2(NUM_CORES);
	localparam int CNT_W    = $clog2(NUM_CORES + 1);
	localparam int CMP_W    = (CNT_W > CORES_W) ? CNT_W : CORES_W;
	localparam int IDX_X_W  = (IDX_W > CHANGED_W) ? IDX_W : CHANGED_W;
	localparam int MASK_X_W = (NUM_CORES > MASK_W) ? NUM_CORES : MASK_W;
	localparam int CNT_X_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	// Configuration registers.
	logic               enabled_q;
	logic [CORES_W-1:0] max_cores_q;
	logic [CORES_W-1:0] min_cores_q;
	logic [PCT_W-1:0]   up_pct_q;
	logic [PCT_W-1:0]   down_pct_q;
	logic [TICK_W-1:0]  ticks_up_q;
	logic [TICK_W-1:0]  ticks_down_q;

	// Controller state.
	logic [NUM_CORES-1:0] mask_q;
	logic [TICK_W-1:0]    ticks_q;

	// Input register.
	logic              valid_s1;
	cmd_item_t         cmd_s1;
	logic [PROD_W-1:0] up_prod_s1;
	logic [PROD_W-1:0] down_prod_s1;

	logic                 advance;
	logic [NUM_CORES-1:0] mask_nx;
	logic [TICK_W-1:0]    ticks_nx;
	action_t              action_nx;
	logic [IDX_W-1:0]     changed_nx;
	res_item_t            res_nx;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= RST_ENABLED;
			max_cores_q  <= RST_MAX_CORES;
			min_cores_q  <= RST_MIN_CORES;
			up_pct_q     <= RST_UP_PCT;
			down_pct_q   <= RST_DOWN_PCT;
			ticks_up_q   <= RST_TICKS_UP;
			ticks_down_q <= RST_TICKS_DOWN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLED:    enabled_q    <= cfg_data[0];
				CFG_MAX_CORES:  max_cores_q  <= cfg_data[CORES_W-1:0];
				CFG_MIN_CORES:  min_cores_q  <= cfg_data[CORES_W-1:0];
				CFG_UP_PCT:     up_pct_q     <= cfg_data[PCT_W-1:0];
				CFG_DOWN_PCT:   down_pct_q   <= cfg_data[PCT_W-1:0];
				CFG_TICKS_UP:   ticks_up_q   <= cfg_data;
				CFG_TICKS_DOWN: ticks_down_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input register moves on when the result register is free or being emptied.
	assign advance   = valid_s1 && (!res_valid || res_ready);
	assign cmd_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	// Capture a command transfer and form both percent products.
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1       <= cmd;
			up_prod_s1   <= PROD_W'(up_pct_q) * PROD_W'(cmd.peak_rate);
			down_prod_s1 <= PROD_W'(down_pct_q) * PROD_W'(cmd.peak_rate);
		end
	end

	// Decide the hotplug move for the command in the input register.
	always_comb begin
		logic [RATE_W-1:0] rate_in [RATE_INPUTS];
		logic [RATE_W-1:0] core_rate [NUM_CORES];
		logic              have_slow;
		logic [IDX_W-1:0]  slow_core;
		logic [RATE_W-1:0] low_rate;
		logic [RATE_W-1:0] high_rate;
		logic [RATE_W-1:0] min_rate;
		logic              up_hit;
		logic              down_hit;
		logic              add_found;
		logic [IDX_W-1:0]  add_core;
		logic [CNT_W-1:0]  online_cnt;
		logic [CNT_W-1:0]  run_cnt;
		logic [CMP_W-1:0]  max_eff;
		logic [TICK_W-1:0] tick_inc;

		rate_in[0] = cmd_s1.rate_core0;
		rate_in[1] = cmd_s1.rate_core1;
		rate_in[2] = cmd_s1.rate_core2;
		rate_in[3] = cmd_s1.rate_core3;
		for (int c = 0; c < NUM_CORES; c++) begin
			core_rate[c] = '0;
			if (c < RATE_INPUTS) begin
				core_rate[c] = rate_in[c[1:0]];
			end
		end

		// Slowest online core above 0 (later index wins ties); high rate skips slowest-so-far cores.
		have_slow = 1'b0;
		slow_core = '0;
		low_rate  = '0;
		high_rate = core_rate[0];
		for (int c = 1; c < NUM_CORES; c++) begin
			if (mask_q[c]) begin
				if (!have_slow || core_rate[c] <= low_rate) begin
					have_slow = 1'b1;
					slow_core = IDX_W'(c);
					low_rate  = core_rate[c];
				end else if (core_rate[c] > high_rate) begin
					high_rate = core_rate[c];
				end
			end
		end
		min_rate = (!have_slow || core_rate[0] < low_rate) ? core_rate[0] : low_rate;

		// Limit tests without division.
		up_hit   = (SCALED_W'(up_prod_s1) + SCALED_W'(PCT_SCALE)) < scale_rate(min_rate);
		down_hit = scale_rate(high_rate) <= SCALED_W'(down_prod_s1);

		// Lowest offline core from 1 upward.
		add_found = 1'b0;
		add_core  = '0;
		for (int c = 1; c < NUM_CORES; c++) begin
			if (!mask_q[c] && !add_found) begin
				add_found = 1'b1;
				add_core  = IDX_W'(c);
			end
		end

		online_cnt = CNT_W'($countones(mask_q));
		max_eff    = (CMP_W'(max_cores_q) < CMP_W'(NUM_CORES)) ?
			CMP_W'(max_cores_q) : CMP_W'(NUM_CORES);
		tick_inc   = (&ticks_q) ? ticks_q : ticks_q + TICK_W'(1);
		run_cnt    = online_cnt;

		mask_nx    = mask_q;
		ticks_nx   = ticks_q;
		action_nx  = ACT_NONE;
		changed_nx = '0;

		if (enabled_q) begin
			case (cmd_s1.func)
				FUNC_TICK: begin
					ticks_nx = tick_inc;
					if (up_hit) begin
						if (CMP_W'(online_cnt) < max_eff && tick_inc >= ticks_up_q
							&& add_found) begin
							mask_nx[add_core] = 1'b1;
							action_nx  = ACT_ONLINE;
							changed_nx = add_core;
							ticks_nx   = '0;
						end
					end else if (have_slow && down_hit) begin
						if (CMP_W'(online_cnt) > CMP_W'(min_cores_q)
							&& tick_inc >= ticks_down_q) begin
							mask_nx[slow_core] = 1'b0;
							action_nx  = ACT_OFFLINE;
							changed_nx = slow_core;
							ticks_nx   = '0;
						end
					end
				end
				FUNC_SUSPEND: begin
					for (int c = 1; c < NUM_CORES; c++) begin
						if (mask_nx[c] && CMP_W'(run_cnt) > CMP_W'(min_cores_q)) begin
							mask_nx[c] = 1'b0;
							run_cnt    = run_cnt - CNT_W'(1);
						end
					end
					if (mask_nx != mask_q) begin
						action_nx = ACT_MASK;
					end
				end
				FUNC_RESUME: begin
					for (int c = 0; c < NUM_CORES; c++) begin
						if (!mask_nx[c] && CMP_W'(run_cnt) < max_eff) begin
							mask_nx[c] = 1'b1;
							run_cnt    = run_cnt + CNT_W'(1);
						end
					end
					if (mask_nx != mask_q) begin
						action_nx = ACT_MASK;
					end
				end
				default: ;
			endcase
		end
	end

	// Result fields, truncated to the transfer widths.
	always_comb begin
		logic [IDX_X_W-1:0]  changed_x;
		logic [MASK_X_W-1:0] mask_x;
		logic [CNT_X_W-1:0]  count_x;

		changed_x = IDX_X_W'(changed_nx);
		mask_x    = MASK_X_W'(mask_nx);
		count_x   = CNT_X_W'($countones(mask_nx));

		res_nx.action       = action_nx;
		res_nx.changed_core = changed_x[CHANGED_W-1:0];
		res_nx.online_mask  = mask_x[MASK_W-1:0];
		res_nx.online_count = count_x[COUNT_W-1:0];
	end

	// State update and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '1;
			ticks_q   <= '0;
			res_valid <= 1'b0;
		end else begin
			if (advance) begin
				mask_q    <= mask_nx;
				ticks_q   <= ticks_nx;
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res <= res_nx;
		end
	end

endmodule

// ----- src/lbch_checker.sv -----
// Port-level checker for the load-based core hotplug controller, with its bind.
// Depends on lbch_pkg for the result transfer type and action codes.
module lbch_checker
	import lbch_pkg::*;
#(
	parameter int NUM_CORES = 4
) (
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_ready,
	input res_item_t res
);

	// A stalled result transfer holds its value.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// The reported count matches the reported mask when every core fits in the mask.
	a_count_mask: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && NUM_CORES <= MASK_W |-> res.online_count == $countones(res.online_mask))
		else $error("online count disagrees with mask");

	// Only a single-core move names a core.
	a_changed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.action == ACT_NONE || res.action == ACT_MASK)
		|-> res.changed_core == '0)
		else $error("changed core set without a single-core move");

	// A single-core move never touches core 0 and leaves the named core in its new state.
	a_move_bit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && NUM_CORES <= MASK_W
		&& (res.action == ACT_ONLINE || res.action == ACT_OFFLINE)
		|-> res.changed_core != '0
		&& res.online_mask[res.changed_core] == (res.action == ACT_ONLINE))
		else $error("single-core move inconsistent with mask");

endmodule

bind load_based_core_hotplug lbch_checker #(.NUM_CORES(NUM_CORES)) u_lbch_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
